FILE: rtl/sit_pkg.sv
// Shared constants and types for the segment intersection test core.
package sit_pkg;

  // Default width of one signed coordinate.
  localparam int unsigned COORD_BITS_DEF = 16;

  // Outcomes of the parallel-pair checks, carried alongside the arithmetic.
  typedef struct packed {
    logic vert;   // both segments vertical
    logic vmeet;  // same vertical line and y intervals overlap
    logic horz;   // both segments horizontal
    logic hmeet;  // same horizontal line and x intervals overlap
  } flags_t;

endpackage

FILE: rtl/sit_in_if.sv
// Request channel carrying the endpoints of two segments.
interface sit_in_if #(
  parameter int unsigned COORD_BITS = sit_pkg::COORD_BITS_DEF
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] seg_a_start_x;
  logic signed [COORD_BITS-1:0] seg_a_start_y;
  logic signed [COORD_BITS-1:0] seg_a_end_x;
  logic signed [COORD_BITS-1:0] seg_a_end_y;
  logic signed [COORD_BITS-1:0] seg_b_start_x;
  logic signed [COORD_BITS-1:0] seg_b_start_y;
  logic signed [COORD_BITS-1:0] seg_b_end_x;
  logic signed [COORD_BITS-1:0] seg_b_end_y;

  modport source (
    output valid, seg_a_start_x, seg_a_start_y, seg_a_end_x, seg_a_end_y,
           seg_b_start_x, seg_b_start_y, seg_b_end_x, seg_b_end_y,
    input  ready
  );

  modport sink (
    input  valid, seg_a_start_x, seg_a_start_y, seg_a_end_x, seg_a_end_y,
           seg_b_start_x, seg_b_start_y, seg_b_end_x, seg_b_end_y,
    output ready
  );
endinterface

FILE: rtl/sit_out_if.sv
// Result channel carrying the intersection verdict.
interface sit_out_if;
  logic valid;
  logic ready;
  logic intersects;
  logic unsupported;

  modport source (output valid, intersects, unsupported, input ready);
  modport sink (input valid, intersects, unsupported, output ready);
endinterface

FILE: rtl/sit_diff.sv
// First stage: direction vectors, offsets and the axis-aligned overlap checks.
module sit_diff #(
  parameter  int unsigned COORD_BITS = sit_pkg::COORD_BITS_DEF,
  localparam int unsigned DW         = COORD_BITS + 1
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         valid_i,
  output logic                         ready_o,
  input  logic signed [COORD_BITS-1:0] x1_i,
  input  logic signed [COORD_BITS-1:0] y1_i,
  input  logic signed [COORD_BITS-1:0] x2_i,
  input  logic signed [COORD_BITS-1:0] y2_i,
  input  logic signed [COORD_BITS-1:0] x3_i,
  input  logic signed [COORD_BITS-1:0] y3_i,
  input  logic signed [COORD_BITS-1:0] x4_i,
  input  logic signed [COORD_BITS-1:0] y4_i,
  output logic                         valid_o,
  input  logic                         ready_i,
  output logic signed [DW-1:0]         ax_o,
  output logic signed [DW-1:0]         ay_o,
  output logic signed [DW-1:0]         bx_o,
  output logic signed [DW-1:0]         by_o,
  output logic signed [DW-1:0]         dx_o,
  output logic signed [DW-1:0]         dy_o,
  output sit_pkg::flags_t              flags_o
);

  // Closed intervals with unordered ends overlap.
  function automatic logic spans_meet(input logic signed [COORD_BITS-1:0] a0,
                                      input logic signed [COORD_BITS-1:0] a1,
                                      input logic signed [COORD_BITS-1:0] b0,
                                      input logic signed [COORD_BITS-1:0] b1);
    logic signed [COORD_BITS-1:0] alo;
    logic signed [COORD_BITS-1:0] ahi;
    logic signed [COORD_BITS-1:0] blo;
    logic signed [COORD_BITS-1:0] bhi;
    alo = (a0 < a1) ? a0 : a1;
    ahi = (a0 < a1) ? a1 : a0;
    blo = (b0 < b1) ? b0 : b1;
    bhi = (b0 < b1) ? b1 : b0;
    return (alo <= bhi) && (blo <= ahi);
  endfunction

  function automatic logic signed [DW-1:0] sub_ext(input logic signed [COORD_BITS-1:0] a,
                                                   input logic signed [COORD_BITS-1:0] b);
    return $signed({a[COORD_BITS-1], a}) - $signed({b[COORD_BITS-1], b});
  endfunction

  logic                 valid_q;
  logic signed [DW-1:0] ax_q, ay_q, bx_q, by_q, dx_q, dy_q;
  sit_pkg::flags_t      flags_d, flags_q;

  assign ready_o = !valid_q || ready_i;

  always_comb begin
    flags_d.vert  = (x1_i == x2_i) && (x3_i == x4_i);
    flags_d.vmeet = (x1_i == x3_i) && spans_meet(y1_i, y2_i, y3_i, y4_i);
    flags_d.horz  = (y1_i == y2_i) && (y3_i == y4_i);
    flags_d.hmeet = (y1_i == y3_i) && spans_meet(x1_i, x2_i, x3_i, x4_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      ax_q    <= sub_ext(x2_i, x1_i);
      ay_q    <= sub_ext(y2_i, y1_i);
      bx_q    <= sub_ext(x3_i, x4_i);
      by_q    <= sub_ext(y3_i, y4_i);
      dx_q    <= sub_ext(x3_i, x1_i);
      dy_q    <= sub_ext(y3_i, y1_i);
      flags_q <= flags_d;
    end
  end

  assign valid_o = valid_q;
  assign ax_o    = ax_q;
  assign ay_o    = ay_q;
  assign bx_o    = bx_q;
  assign by_o    = by_q;
  assign dx_o    = dx_q;
  assign dy_o    = dy_q;
  assign flags_o = flags_q;

endmodule

FILE: rtl/sit_mul.sv
// Second stage: the six cross-product terms.
module sit_mul #(
  parameter  int unsigned COORD_BITS = sit_pkg::COORD_BITS_DEF,
  localparam int unsigned DW         = COORD_BITS + 1,
  localparam int unsigned PW         = 2 * DW
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  output logic                 ready_o,
  input  logic signed [DW-1:0] ax_i,
  input  logic signed [DW-1:0] ay_i,
  input  logic signed [DW-1:0] bx_i,
  input  logic signed [DW-1:0] by_i,
  input  logic signed [DW-1:0] dx_i,
  input  logic signed [DW-1:0] dy_i,
  input  sit_pkg::flags_t      flags_i,
  output logic                 valid_o,
  input  logic                 ready_i,
  output logic signed [PW-1:0] ax_by_o,
  output logic signed [PW-1:0] ay_bx_o,
  output logic signed [PW-1:0] dx_by_o,
  output logic signed [PW-1:0] dy_bx_o,
  output logic signed [PW-1:0] ax_dy_o,
  output logic signed [PW-1:0] ay_dx_o,
  output sit_pkg::flags_t      flags_o
);

  logic                 valid_q;
  logic signed [PW-1:0] ax_by_q, ay_bx_q, dx_by_q, dy_bx_q, ax_dy_q, ay_dx_q;
  sit_pkg::flags_t      flags_q;

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      ax_by_q <= ax_i * by_i;
      ay_bx_q <= ay_i * bx_i;
      dx_by_q <= dx_i * by_i;
      dy_bx_q <= dy_i * bx_i;
      ax_dy_q <= ax_i * dy_i;
      ay_dx_q <= ay_i * dx_i;
      flags_q <= flags_i;
    end
  end

  assign valid_o = valid_q;
  assign ax_by_o = ax_by_q;
  assign ay_bx_o = ay_bx_q;
  assign dx_by_o = dx_by_q;
  assign dy_bx_o = dy_bx_q;
  assign ax_dy_o = ax_dy_q;
  assign ay_dx_o = ay_dx_q;
  assign flags_o = flags_q;

endmodule

FILE: rtl/sit_sub.sv
// Third stage: determinant and the two parameter numerators.
module sit_sub #(
  parameter  int unsigned COORD_BITS = sit_pkg::COORD_BITS_DEF,
  localparam int unsigned PW         = 2 * (COORD_BITS + 1),
  localparam int unsigned SW         = PW + 1
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  output logic                 ready_o,
  input  logic signed [PW-1:0] ax_by_i,
  input  logic signed [PW-1:0] ay_bx_i,
  input  logic signed [PW-1:0] dx_by_i,
  input  logic signed [PW-1:0] dy_bx_i,
  input  logic signed [PW-1:0] ax_dy_i,
  input  logic signed [PW-1:0] ay_dx_i,
  input  sit_pkg::flags_t      flags_i,
  output logic                 valid_o,
  input  logic                 ready_i,
  output logic signed [SW-1:0] det_o,
  output logic signed [SW-1:0] rn_o,
  output logic signed [SW-1:0] sn_o,
  output sit_pkg::flags_t      flags_o
);

  function automatic logic signed [SW-1:0] sub_ext(input logic signed [PW-1:0] a,
                                                   input logic signed [PW-1:0] b);
    return $signed({a[PW-1], a}) - $signed({b[PW-1], b});
  endfunction

  logic                 valid_q;
  logic signed [SW-1:0] det_q, rn_q, sn_q;
  sit_pkg::flags_t      flags_q;

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      det_q   <= sub_ext(ax_by_i, ay_bx_i);
      rn_q    <= sub_ext(dx_by_i, dy_bx_i);
      sn_q    <= sub_ext(ax_dy_i, ay_dx_i);
      flags_q <= flags_i;
    end
  end

  assign valid_o = valid_q;
  assign det_o   = det_q;
  assign rn_o    = rn_q;
  assign sn_o    = sn_q;
  assign flags_o = flags_q;

endmodule

FILE: rtl/sit_decide.sv
// Fourth stage: parameter range tests, parallel-pair selection and result register.
module sit_decide #(
  parameter  int unsigned COORD_BITS = sit_pkg::COORD_BITS_DEF,
  localparam int unsigned SW         = 2 * (COORD_BITS + 1) + 1
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  output logic                 ready_o,
  input  logic signed [SW-1:0] det_i,
  input  logic signed [SW-1:0] rn_i,
  input  logic signed [SW-1:0] sn_i,
  input  sit_pkg::flags_t      flags_i,
  output logic                 valid_o,
  input  logic                 ready_i,
  output logic                 intersects_o,
  output logic                 unsupported_o
);

  // 0 <= num/den <= 1 for a nonzero den, compared without dividing.
  function automatic logic unit_param(input logic signed [SW-1:0] num,
                                      input logic signed [SW-1:0] den);
    logic ok;
    if (!den[SW-1]) begin
      ok = !num[SW-1] && (num <= den);
    end else begin
      ok = (num[SW-1] || (num == '0)) && (num >= den);
    end
    return ok;
  endfunction

  logic valid_q;
  logic hit_d, hit_q;
  logic unsup_d, unsup_q;

  assign ready_o = !valid_q || ready_i;

  always_comb begin
    hit_d   = 1'b0;
    unsup_d = 1'b0;
    if (det_i != '0) begin
      hit_d = unit_param(rn_i, det_i) && unit_param(sn_i, det_i);
    end else if (flags_i.vert) begin
      hit_d = flags_i.vmeet;
    end else if (flags_i.horz) begin
      hit_d = flags_i.hmeet;
    end else begin
      unsup_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      hit_q   <= hit_d;
      unsup_q <= unsup_d;
    end
  end

  assign valid_o       = valid_q;
  assign intersects_o  = hit_q;
  assign unsupported_o = unsup_q;

endmodule

FILE: rtl/segment_intersection_test_core.sv
// Top level of the four-stage segment intersection test pipeline.
// A request passes the diff, mul, sub and decide registers, each with its own valid bit.
// Throughput: one request per cycle while the result is not stalled.
// A stalled result only holds the stages behind it that are full; bubbles still fill.
// Reset (asynchronous, active low) clears all valid bits; payload registers are not reset.
module segment_intersection_test_core #(
  parameter int unsigned COORD_BITS = sit_pkg::COORD_BITS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  sit_in_if.sink    seg_i,
  sit_out_if.source res_o
);

  localparam int unsigned DW = COORD_BITS + 1;
  localparam int unsigned PW = 2 * DW;
  localparam int unsigned SW = PW + 1;

  logic                 s1_valid, s2_valid, s3_valid;
  logic                 s2_ready, s3_ready, s4_ready;
  logic signed [DW-1:0] ax, ay, bx, by, dx, dy;
  logic signed [PW-1:0] ax_by, ay_bx, dx_by, dy_bx, ax_dy, ay_dx;
  logic signed [SW-1:0] det, rn, sn;
  sit_pkg::flags_t      s1_flags, s2_flags, s3_flags;

  sit_diff #(.COORD_BITS(COORD_BITS)) u_diff (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (seg_i.valid),
    .ready_o (seg_i.ready),
    .x1_i    (seg_i.seg_a_start_x),
    .y1_i    (seg_i.seg_a_start_y),
    .x2_i    (seg_i.seg_a_end_x),
    .y2_i    (seg_i.seg_a_end_y),
    .x3_i    (seg_i.seg_b_start_x),
    .y3_i    (seg_i.seg_b_start_y),
    .x4_i    (seg_i.seg_b_end_x),
    .y4_i    (seg_i.seg_b_end_y),
    .valid_o (s1_valid),
    .ready_i (s2_ready),
    .ax_o    (ax),
    .ay_o    (ay),
    .bx_o    (bx),
    .by_o    (by),
    .dx_o    (dx),
    .dy_o    (dy),
    .flags_o (s1_flags)
  );

  sit_mul #(.COORD_BITS(COORD_BITS)) u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s1_valid),
    .ready_o (s2_ready),
    .ax_i    (ax),
    .ay_i    (ay),
    .bx_i    (bx),
    .by_i    (by),
    .dx_i    (dx),
    .dy_i    (dy),
    .flags_i (s1_flags),
    .valid_o (s2_valid),
    .ready_i (s3_ready),
    .ax_by_o (ax_by),
    .ay_bx_o (ay_bx),
    .dx_by_o (dx_by),
    .dy_bx_o (dy_bx),
    .ax_dy_o (ax_dy),
    .ay_dx_o (ay_dx),
    .flags_o (s2_flags)
  );

  sit_sub #(.COORD_BITS(COORD_BITS)) u_sub (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s2_valid),
    .ready_o (s3_ready),
    .ax_by_i (ax_by),
    .ay_bx_i (ay_bx),
    .dx_by_i (dx_by),
    .dy_bx_i (dy_bx),
    .ax_dy_i (ax_dy),
    .ay_dx_i (ay_dx),
    .flags_i (s2_flags),
    .valid_o (s3_valid),
    .ready_i (s4_ready),
    .det_o   (det),
    .rn_o    (rn),
    .sn_o    (sn),
    .flags_o (s3_flags)
  );

  sit_decide #(.COORD_BITS(COORD_BITS)) u_decide (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .valid_i       (s3_valid),
    .ready_o       (s4_ready),
    .det_i         (det),
    .rn_i          (rn),
    .sn_i          (sn),
    .flags_i       (s3_flags),
    .valid_o       (res_o.valid),
    .ready_i       (res_o.ready),
    .intersects_o  (res_o.intersects),
    .unsupported_o (res_o.unsupported)
  );

`ifndef SYNTHESIS
  // The input side can only be blocked when every stage is full and the result is stalled.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !seg_i.ready |-> (res_o.valid && !res_o.ready))
    else $error("input blocked while the pipeline still has room");

  // A result that newly appears was accepted earlier and passed the diff, mul, sub and decide registers.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(res_o.valid) |-> $past(seg_i.valid && seg_i.ready, 4))
    else $error("result appeared without a matching request");

  // An unsupported pair never reports a hit.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && res_o.unsupported) |-> !res_o.intersects)
    else $error("unsupported pair flagged as intersecting");
`endif

endmodule

FILE: sim/sit_verdict_checker.sv
// Checker that predicts the intersection verdict of each request and compares the results.
`timescale 1ns / 100ps
module sit_verdict_checker #(
  parameter int unsigned COORD_BITS = sit_pkg::COORD_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         req_valid_i,
  input  logic                         req_ready_i,
  input  logic signed [COORD_BITS-1:0] a_start_x_i,
  input  logic signed [COORD_BITS-1:0] a_start_y_i,
  input  logic signed [COORD_BITS-1:0] a_end_x_i,
  input  logic signed [COORD_BITS-1:0] a_end_y_i,
  input  logic signed [COORD_BITS-1:0] b_start_x_i,
  input  logic signed [COORD_BITS-1:0] b_start_y_i,
  input  logic signed [COORD_BITS-1:0] b_end_x_i,
  input  logic signed [COORD_BITS-1:0] b_end_y_i,
  input  logic                         res_valid_i,
  input  logic                         res_ready_i,
  input  logic                         res_intersects_i,
  input  logic                         res_unsupported_i,
  output int                           fail_count_o,
  output int                           pending_o
);

  typedef struct packed {
    logic intersects;
    logic unsupported;
  } verdict_t;

  verdict_t verdict_q[$];
  int       fails = 0;

  // True when 0 <= num/den <= 1 for a nonzero den, decided without dividing.
  function automatic bit param_in_unit(longint num, longint den);
    longint n;
    longint d;
    n = num;
    d = den;
    if (d < 0) begin
      n = -n;
      d = -d;
    end
    return (n >= 0) && (n <= d);
  endfunction

  // Closed intervals whose ends may come in either order.
  function automatic bit spans_overlap(longint a0, longint a1, longint b0, longint b1);
    longint lo_a;
    longint hi_a;
    longint lo_b;
    longint hi_b;
    lo_a = (a0 < a1) ? a0 : a1;
    hi_a = (a0 > a1) ? a0 : a1;
    lo_b = (b0 < b1) ? b0 : b1;
    hi_b = (b0 > b1) ? b0 : b1;
    return ((lo_a > lo_b) ? lo_a : lo_b) <= ((hi_a < hi_b) ? hi_a : hi_b);
  endfunction

  function automatic verdict_t predict_verdict(longint x1, longint y1, longint x2, longint y2,
                                               longint x3, longint y3, longint x4, longint y4);
    verdict_t v;
    longint   ax;
    longint   ay;
    longint   bx;
    longint   by;
    longint   dx;
    longint   dy;
    longint   det;
    longint   rn;
    longint   sn;
    v  = '0;
    ax = x2 - x1;
    ay = y2 - y1;
    bx = x3 - x4;
    by = y3 - y4;
    dx = x3 - x1;
    dy = y3 - y1;
    det = ax * by - ay * bx;
    if (det != 0) begin
      rn = dx * by - dy * bx;
      sn = ax * dy - ay * dx;
      v.intersects = param_in_unit(rn, det) && param_in_unit(sn, det);
    end else if (x1 == x2 && x3 == x4) begin
      // A point counts as vertical, so this branch is tried first.
      v.intersects = (x1 == x3) && spans_overlap(y1, y2, y3, y4);
    end else if (y1 == y2 && y3 == y4) begin
      v.intersects = (y1 == y3) && spans_overlap(x1, x2, x3, x4);
    end else begin
      v.unsupported = 1'b1;
    end
    return v;
  endfunction

  always @(posedge clk_i) begin : track
    verdict_t want;
    if (rst_ni) begin
      if (res_valid_i && res_ready_i) begin
        if (verdict_q.size() == 0) begin
          $display("%0t: result without request: expected none, actual intersects %0b unsupported %0b",
                   $time, res_intersects_i, res_unsupported_i);
          fails++;
        end else begin
          want = verdict_q.pop_front();
          if (res_intersects_i !== want.intersects) begin
            $display("%0t: intersects mismatch: expected %0b, actual %0b",
                     $time, want.intersects, res_intersects_i);
            fails++;
          end
          if (res_unsupported_i !== want.unsupported) begin
            $display("%0t: unsupported mismatch: expected %0b, actual %0b",
                     $time, want.unsupported, res_unsupported_i);
            fails++;
          end
        end
      end
      if (req_valid_i && req_ready_i) begin
        verdict_q.push_back(predict_verdict(a_start_x_i, a_start_y_i, a_end_x_i, a_end_y_i,
                                            b_start_x_i, b_start_y_i, b_end_x_i, b_end_y_i));
      end
      fail_count_o <= fails;
      pending_o    <= verdict_q.size();
    end
  end

endmodule

FILE: sim/segment_intersection_test_core_tb.sv
// Stimulus, clocking and verdict for the segment intersection test core.
`timescale 1ns / 100ps
module segment_intersection_test_core_tb;

  localparam int unsigned CB        = sit_pkg::COORD_BITS_DEF;
  localparam int          QUIET_MAX = 2000;
  localparam int          PHASE_LEN = 282;

  typedef logic signed [CB-1:0] coord_t;

  typedef struct packed {
    coord_t a_sx;
    coord_t a_sy;
    coord_t a_ex;
    coord_t a_ey;
    coord_t b_sx;
    coord_t b_sy;
    coord_t b_ex;
    coord_t b_ey;
  } seg_pair_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;
  bit   idle_on = 1'b1;
  int   chk_fails;
  int   chk_pending;
  int   quiet = 0;

  sit_in_if #(.COORD_BITS(CB)) seg_if ();
  sit_out_if                   res_if ();

  segment_intersection_test_core #(.COORD_BITS(CB)) dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .seg_i  (seg_if),
    .res_o  (res_if)
  );

  sit_verdict_checker #(.COORD_BITS(CB)) verdict_chk (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .req_valid_i       (seg_if.valid),
    .req_ready_i       (seg_if.ready),
    .a_start_x_i       (seg_if.seg_a_start_x),
    .a_start_y_i       (seg_if.seg_a_start_y),
    .a_end_x_i         (seg_if.seg_a_end_x),
    .a_end_y_i         (seg_if.seg_a_end_y),
    .b_start_x_i       (seg_if.seg_b_start_x),
    .b_start_y_i       (seg_if.seg_b_start_y),
    .b_end_x_i         (seg_if.seg_b_end_x),
    .b_end_y_i         (seg_if.seg_b_end_y),
    .res_valid_i       (res_if.valid),
    .res_ready_i       (res_if.ready),
    .res_intersects_i  (res_if.intersects),
    .res_unsupported_i (res_if.unsupported),
    .fail_count_o      (chk_fails),
    .pending_o         (chk_pending)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
  end

  // Ends the run if neither channel moves anything for too long.
  always @(posedge clk) begin
    if (!rst_n || (seg_if.valid && seg_if.ready) || (res_if.valid && res_if.ready)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_MAX) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  function automatic seg_pair_t make_pair(int ax0, int ay0, int ax1, int ay1,
                                          int bx0, int by0, int bx1, int by1);
    seg_pair_t p;
    p.a_sx = coord_t'(ax0);
    p.a_sy = coord_t'(ay0);
    p.a_ex = coord_t'(ax1);
    p.a_ey = coord_t'(ay1);
    p.b_sx = coord_t'(bx0);
    p.b_sy = coord_t'(by0);
    p.b_ex = coord_t'(bx1);
    p.b_ey = coord_t'(by1);
    return p;
  endfunction

  function automatic int near(int centre, int span);
    return centre + int'($urandom_range(0, 2 * span)) - span;
  endfunction

  function automatic int any_coord();
    coord_t c;
    c = coord_t'($urandom);
    return int'(c);
  endfunction

  function automatic int extreme_coord();
    case ($urandom_range(0, 5))
      0: return -32768;
      1: return 32767;
      2: return 0;
      3: return -1;
      4: return 1;
      default: return any_coord();
    endcase
  endfunction

  // Mostly shaped pairs (axis-aligned, degenerate, parallel, touching) with random content.
  function automatic seg_pair_t random_pair();
    seg_pair_t p;
    int        cx;
    int        cy;
    int        dx;
    int        dy;
    int        k;
    int        tx;
    int        ty;
    cx = near(0, 30000);
    cy = near(0, 30000);
    case ($urandom_range(0, 9))
      0, 1: begin
        p = make_pair(any_coord(), any_coord(), any_coord(), any_coord(),
                      any_coord(), any_coord(), any_coord(), any_coord());
      end
      2, 3: begin
        p = make_pair(near(cx, 12), near(cy, 12), near(cx, 12), near(cy, 12),
                      near(cx, 12), near(cy, 12), near(cx, 12), near(cy, 12));
      end
      4: begin
        tx = near(cx, 1);
        p = make_pair(cx, near(cy, 20), cx, near(cy, 20), tx, near(cy, 20), tx, near(cy, 20));
      end
      5: begin
        ty = near(cy, 1);
        p = make_pair(near(cx, 20), cy, near(cx, 20), cy, near(cx, 20), ty, near(cx, 20), ty);
      end
      6: begin
        k  = near(0, 20);
        tx = near(cx, 1);
        ty = near(cy, 1);
        case ($urandom_range(0, 3))
          0: p = make_pair(cx, cy, cx, cy, tx, ty, tx, ty);
          1: p = make_pair(cx, cy, cx, cy, tx, near(cy, 10), tx, near(cy, 10));
          2: p = make_pair(cx, cy, cx, cy, near(cx, 10), ty, near(cx, 10), ty);
          default: p = make_pair(cx, cy, cx, cy, tx - k, ty - k, tx + k, ty + k);
        endcase
      end
      7: begin
        // Same direction, shifted along it and sometimes off it.
        dx = near(0, 20);
        dy = near(0, 20);
        k  = near(0, 3);
        tx = k * dx + ($urandom_range(0, 1) ? near(0, 2) : 0);
        ty = k * dy + ($urandom_range(0, 1) ? near(0, 2) : 0);
        if ($urandom_range(0, 1)) begin
          p = make_pair(cx, cy, cx + dx, cy + dy, cx + tx, cy + ty, cx + tx + dx, cy + ty + dy);
        end else begin
          p = make_pair(cx, cy, cx + dx, cy + dy, cx + tx + dx, cy + ty + dy, cx + tx, cy + ty);
        end
      end
      8: begin
        // B ends exactly on A: at its middle, its end or its start.
        dx = near(0, 20);
        dy = near(0, 20);
        case ($urandom_range(0, 2))
          0: k = 1;
          1: k = 2;
          default: k = 0;
        endcase
        p = make_pair(cx, cy, cx + 2 * dx, cy + 2 * dy,
                      near(cx, 30), near(cy, 30), cx + k * dx, cy + k * dy);
      end
      default: begin
        p = make_pair(extreme_coord(), extreme_coord(), extreme_coord(), extreme_coord(),
                      extreme_coord(), extreme_coord(), extreme_coord(), extreme_coord());
      end
    endcase
    if ($urandom_range(0, 1)) begin
      p = make_pair(p.b_sx, p.b_sy, p.b_ex, p.b_ey, p.a_sx, p.a_sy, p.a_ex, p.a_ey);
    end
    return p;
  endfunction

  // Leaves valid high after acceptance, so a request with no gap follows straight on.
  task automatic send_pair(input seg_pair_t p);
    int gap;
    gap = idle_on ? $urandom_range(0, 7) : 0;
    if (gap > 0) begin
      seg_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    seg_if.valid         <= 1'b1;
    seg_if.seg_a_start_x <= p.a_sx;
    seg_if.seg_a_start_y <= p.a_sy;
    seg_if.seg_a_end_x   <= p.a_ex;
    seg_if.seg_a_end_y   <= p.a_ey;
    seg_if.seg_b_start_x <= p.b_sx;
    seg_if.seg_b_start_y <= p.b_sy;
    seg_if.seg_b_end_x   <= p.b_ex;
    seg_if.seg_b_end_y   <= p.b_ey;
    do @(posedge clk); while (!seg_if.ready);
  endtask

  // Holds off new requests until every outstanding verdict has come back.
  task automatic drain_results();
    seg_if.valid <= 1'b0;
    @(posedge clk);
    while (chk_pending != 0) @(posedge clk);
  endtask

  initial begin : result_sink
    int stall;
    res_if.ready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      stall = idle_on ? $urandom_range(0, 7) : 0;
      if (stall > 0) begin
        res_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      res_if.ready <= 1'b1;
      do @(posedge clk); while (res_if.valid !== 1'b1);
    end
  end

  initial begin : stimulus
    seg_if.valid         <= 1'b0;
    seg_if.seg_a_start_x <= '0;
    seg_if.seg_a_start_y <= '0;
    seg_if.seg_a_end_x   <= '0;
    seg_if.seg_a_end_y   <= '0;
    seg_if.seg_b_start_x <= '0;
    seg_if.seg_b_start_y <= '0;
    seg_if.seg_b_end_x   <= '0;
    seg_if.seg_b_end_y   <= '0;
    do @(posedge clk); while (!rst_n);

    // Crossings, near misses and extremes of the range.
    send_pair(make_pair(-10, 0, 10, 0, 0, -10, 0, 10));
    send_pair(make_pair(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768));
    send_pair(make_pair(32767, -32768, -32768, 32767, -32768, -32768, 32767, 32767));
    send_pair(make_pair(0, 0, 10, 0, 10, 0, 10, 10));
    send_pair(make_pair(0, 0, 10, 0, 11, -5, 11, 5));
    send_pair(make_pair(0, 0, 10, 10, 0, 10, 10, 0));
    send_pair(make_pair(0, 0, 4, 4, 5, 0, 6, -1));
    // Both vertical.
    send_pair(make_pair(5, 0, 5, 10, 5, 8, 5, 20));
    send_pair(make_pair(5, 0, 5, 10, 5, 11, 5, 20));
    send_pair(make_pair(5, 10, 5, 0, 5, 20, 5, 10));
    send_pair(make_pair(5, 0, 5, 10, 6, 0, 6, 10));
    // Both horizontal.
    send_pair(make_pair(-32768, 7, 32767, 7, 0, 7, 3, 7));
    send_pair(make_pair(0, 7, 10, 7, 20, 7, 11, 7));
    send_pair(make_pair(0, 7, 10, 7, 0, 8, 10, 8));
    // Parallel but not axis aligned.
    send_pair(make_pair(0, 0, 5, 5, 1, 1, 6, 6));
    send_pair(make_pair(0, 0, 5, 5, 0, 1, 5, 6));
    // Pairs in which one or both segments are single points.
    send_pair(make_pair(3, 3, 3, 3, 3, 3, 3, 3));
    send_pair(make_pair(3, 3, 3, 3, 4, 3, 4, 3));
    send_pair(make_pair(2, 5, 2, 5, 2, 0, 2, 9));
    send_pair(make_pair(4, 1, 4, 1, 0, 1, 9, 1));
    send_pair(make_pair(1, 1, 1, 1, 0, 0, 2, 2));
    send_pair(make_pair(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768));
    send_pair(make_pair(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767));
    drain_results();

    // Phases alternate between random idling and back-to-back traffic.
    for (int phase = 0; phase < 4; phase++) begin
      idle_on = (phase % 2) == 0;
      for (int n = 0; n < PHASE_LEN; n++) begin
        send_pair(random_pair());
      end
      drain_results();
    end

    repeat (16) @(posedge clk);
    if (chk_fails == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/sit_pkg.sv
rtl/sit_in_if.sv
rtl/sit_out_if.sv
rtl/sit_diff.sv
rtl/sit_mul.sv
rtl/sit_sub.sv
rtl/sit_decide.sv
rtl/segment_intersection_test_core.sv
sim/sit_verdict_checker.sv
sim/segment_intersection_test_core_tb.sv
